FILE: rtl/mer_pkg.sv
// shared types and codes of the midpoint ellipse rasterizer
`timescale 1ns / 1ps
package mer_pkg;

  // input opcode values
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RX2,
    ST_S_RY2,
    ST_S_SLOPE,
    ST_S_INIT,
    ST_R_AA,
    ST_R_RYAA,
    ST_R_BB,
    ST_R_RXBB,
    ST_R_RXRY,
    ST_R_DONE,
    ST_EMIT
  } mer_state_e;

endpackage

FILE: rtl/mer_in_if.sv
// input channel of the ellipse rasterizer: opcode, center and radii
`timescale 1ns / 1ps
interface mer_in_if #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  modport source (
    output valid, opcode, center_x, center_y, radius_x, radius_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, center_x, center_y, radius_x, radius_y,
    output ready
  );
endinterface

FILE: rtl/mer_out_if.sv
// output channel of the ellipse rasterizer: four symmetric coordinates and last flag
`timescale 1ns / 1ps
interface mer_out_if #(
  parameter int COORD_BITS = 10
);
  localparam int OUT_BITS = COORD_BITS + 2;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] right_x;
  logic signed [OUT_BITS-1:0] left_x;
  logic signed [OUT_BITS-1:0] lower_y;
  logic signed [OUT_BITS-1:0] upper_y;
  logic                       last;

  modport source (
    output valid, right_x, left_x, lower_y, upper_y, last,
    input  ready
  );
  modport sink (
    input  valid, right_x, left_x, lower_y, upper_y, last,
    output ready
  );
endinterface

FILE: rtl/midpoint_ellipse_rasterizer_core.sv
// midpoint ellipse rasterizer: start sets up a run, each step of an active run emits one symmetric point
// start item: accept, three shared-multiplier passes, decision setup, no result
// step item: accept plus update, the update waiting while a held result blocks it
// region switch step: five shared-multiplier passes and a final subtract before the update
// steps with no active run are accepted and ignored; input is not ready while a start or step is in work
// rst_ni asynchronously clears sequencer, run state and output valid, not product or payload
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_core
  import mer_pkg::*;
#(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mer_in_if.sink     in_i,
  mer_out_if.source  out_o
);

  localparam int OUT_BITS   = COORD_BITS + 2;
  localparam int OFF_BITS   = RADIUS_BITS + 1;
  localparam int SQ_BITS    = 2 * RADIUS_BITS;
  localparam int MA_BITS    = SQ_BITS;
  localparam int MB_BITS    = SQ_BITS + 4;
  localparam int P_BITS     = MA_BITS + MB_BITS;
  localparam int SLOPE_BITS = (3 * RADIUS_BITS + 4 > 64) ? 64 : 3 * RADIUS_BITS + 4;
  localparam int DEC_BITS   = (4 * RADIUS_BITS + 6 > 64) ? 64 : 4 * RADIUS_BITS + 6;
  localparam int EXT_BITS   = (OUT_BITS > OFF_BITS) ? OUT_BITS : OFF_BITS;

  mer_state_e state_q, state_d;

  logic                   active_q, active_d;
  logic                   rg2_q, rg2_d;
  logic [OFF_BITS-1:0]    off_x_q, off_x_d;
  logic [OFF_BITS-1:0]    off_y_q, off_y_d;
  logic [SLOPE_BITS-1:0]  slope_x_q, slope_x_d;
  logic [SLOPE_BITS-1:0]  slope_y_q, slope_y_d;
  logic [DEC_BITS-1:0]    dec_q, dec_d;
  logic [COORD_BITS-1:0]  cx_q, cx_d;
  logic [COORD_BITS-1:0]  cy_q, cy_d;
  logic [RADIUS_BITS-1:0] rx_q, rx_d;
  logic [RADIUS_BITS-1:0] ry_q, ry_d;
  logic [SQ_BITS-1:0]     rx2_q, rx2_d;
  logic [SQ_BITS-1:0]     ry2_q, ry2_d;
  logic [P_BITS-1:0]      p_q, p_d;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]    right_x_q, right_x_d;
  logic [OUT_BITS-1:0]    left_x_q, left_x_d;
  logic [OUT_BITS-1:0]    lower_y_q, lower_y_d;
  logic [OUT_BITS-1:0]    upper_y_q, upper_y_d;
  logic                   last_q, last_d;

  // shared multiplier
  logic [MA_BITS-1:0] mul_a;
  logic [MB_BITS-1:0] mul_b;

  logic                  in_fire;
  logic [OFF_BITS+1-1:0] odd_x;
  logic [OFF_BITS-1:0]   y_less;
  logic                  dec_neg;
  logic                  dec_nz;
  logic                  at_last;
  logic                  out_free;
  logic [SLOPE_BITS-1:0] slope_x_inc;
  logic [SLOPE_BITS-1:0] slope_y_dec;
  logic [DEC_BITS-1:0]   sx4;
  logic [DEC_BITS-1:0]   sy4;
  logic [DEC_BITS-1:0]   rx2_x4;
  logic [DEC_BITS-1:0]   ry2_x4;
  logic [EXT_BITS-1:0]   cx_w, cy_w, ox_w, oy_w;
  logic [EXT_BITS-1:0]   rx_sum, lx_sum, ly_sum, uy_sum;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.right_x = right_x_q;
  assign out_o.left_x  = left_x_q;
  assign out_o.lower_y = lower_y_q;
  assign out_o.upper_y = upper_y_q;
  assign out_o.last    = last_q;
  assign out_free      = !out_valid_q || out_o.ready;

  // 2x+1 and y-1 for the region two setup; y-1 squared is one when y is zero
  assign odd_x   = {off_x_q, 1'b1};
  assign y_less  = (off_y_q == '0) ? OFF_BITS'(1) : off_y_q - OFF_BITS'(1);
  assign dec_neg = dec_q[DEC_BITS-1];
  assign dec_nz  = |dec_q;
  assign at_last = rg2_q && (off_y_q == '0);

  assign slope_x_inc = slope_x_q + SLOPE_BITS'({ry2_q, 1'b0});
  assign slope_y_dec = slope_y_q - SLOPE_BITS'({rx2_q, 1'b0});
  assign sx4         = DEC_BITS'({slope_x_inc, 2'b00});
  assign sy4         = DEC_BITS'({slope_y_dec, 2'b00});
  assign rx2_x4      = DEC_BITS'({rx2_q, 2'b00});
  assign ry2_x4      = DEC_BITS'({ry2_q, 2'b00});

  assign cx_w   = EXT_BITS'(cx_q);
  assign cy_w   = EXT_BITS'(cy_q);
  assign ox_w   = EXT_BITS'(off_x_q);
  assign oy_w   = EXT_BITS'(off_y_q);
  assign rx_sum = cx_w + ox_w;
  assign lx_sum = cx_w - ox_w;
  assign ly_sum = cy_w + oy_w;
  assign uy_sum = cy_w - oy_w;

  // multiplier operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_S_RX2: begin
        mul_a = MA_BITS'(rx_q);
        mul_b = MB_BITS'(rx_q);
      end
      ST_S_RY2: begin
        mul_a = MA_BITS'(ry_q);
        mul_b = MB_BITS'(ry_q);
      end
      ST_S_SLOPE: begin
        mul_a = rx2_q;
        mul_b = MB_BITS'(ry_q);
      end
      ST_R_AA: begin
        mul_a = MA_BITS'(odd_x);
        mul_b = MB_BITS'(odd_x);
      end
      ST_R_RYAA: begin
        mul_a = ry2_q;
        mul_b = p_q[MB_BITS-1:0];
      end
      ST_R_BB: begin
        mul_a = MA_BITS'(y_less);
        mul_b = MB_BITS'(y_less);
      end
      ST_R_RXBB: begin
        mul_a = rx2_q;
        mul_b = p_q[MB_BITS-1:0];
      end
      ST_R_RXRY: begin
        mul_a = rx2_q;
        mul_b = MB_BITS'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_d = mul_a * mul_b;

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    rg2_d       = rg2_q;
    off_x_d     = off_x_q;
    off_y_d     = off_y_q;
    slope_x_d   = slope_x_q;
    slope_y_d   = slope_y_q;
    dec_d       = dec_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    rx2_d       = rx2_q;
    ry2_d       = ry2_q;
    out_valid_d = out_valid_q && !out_o.ready;
    right_x_d   = right_x_q;
    left_x_d    = left_x_q;
    lower_y_d   = lower_y_q;
    upper_y_d   = upper_y_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_START) begin
            cx_d      = in_i.center_x;
            cy_d      = in_i.center_y;
            rx_d      = in_i.radius_x;
            ry_d      = in_i.radius_y;
            off_x_d   = '0;
            off_y_d   = OFF_BITS'(in_i.radius_y);
            slope_x_d = '0;
            rg2_d     = 1'b0;
            active_d  = 1'b1;
            state_d   = ST_S_RX2;
          end else if (active_q) begin
            if (!rg2_q && !(slope_x_q < slope_y_q)) begin
              state_d = ST_R_AA;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_S_RX2: begin
        state_d = ST_S_RY2;
      end
      ST_S_RY2: begin
        rx2_d   = p_q[SQ_BITS-1:0];
        state_d = ST_S_SLOPE;
      end
      ST_S_SLOPE: begin
        ry2_d   = p_q[SQ_BITS-1:0];
        state_d = ST_S_INIT;
      end
      ST_S_INIT: begin
        // p holds rx^2 * ry
        slope_y_d = SLOPE_BITS'({p_q, 1'b0});
        dec_d     = ry2_x4 - DEC_BITS'({p_q, 2'b00}) + DEC_BITS'(rx2_q);
        state_d   = ST_IDLE;
      end
      ST_R_AA: begin
        state_d = ST_R_RYAA;
      end
      ST_R_RYAA: begin
        state_d = ST_R_BB;
      end
      ST_R_BB: begin
        dec_d   = DEC_BITS'(p_q);
        state_d = ST_R_RXBB;
      end
      ST_R_RXBB: begin
        state_d = ST_R_RXRY;
      end
      ST_R_RXRY: begin
        dec_d   = dec_q + DEC_BITS'({p_q, 2'b00});
        state_d = ST_R_DONE;
      end
      ST_R_DONE: begin
        dec_d   = dec_q - DEC_BITS'({p_q, 2'b00});
        rg2_d   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          right_x_d   = rx_sum[OUT_BITS-1:0];
          left_x_d    = lx_sum[OUT_BITS-1:0];
          lower_y_d   = ly_sum[OUT_BITS-1:0];
          upper_y_d   = uy_sum[OUT_BITS-1:0];
          last_d      = at_last;
          state_d     = ST_IDLE;
          if (!rg2_q) begin
            off_x_d   = off_x_q + OFF_BITS'(1);
            slope_x_d = slope_x_inc;
            if (dec_neg) begin
              dec_d = dec_q + sx4 + ry2_x4;
            end else begin
              off_y_d   = off_y_q - OFF_BITS'(1);
              slope_y_d = slope_y_dec;
              dec_d     = dec_q + sx4 - sy4 + ry2_x4;
            end
          end else if (at_last) begin
            active_d = 1'b0;
          end else begin
            off_y_d   = off_y_q - OFF_BITS'(1);
            slope_y_d = slope_y_dec;
            if (!dec_neg && dec_nz) begin
              dec_d = dec_q + rx2_x4 - sy4;
            end else begin
              off_x_d   = off_x_q + OFF_BITS'(1);
              slope_x_d = slope_x_inc;
              dec_d     = dec_q + sx4 - sy4 + rx2_x4;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      rg2_q       <= 1'b0;
      out_valid_q <= 1'b0;
      off_x_q     <= '0;
      off_y_q     <= '0;
      slope_x_q   <= '0;
      slope_y_q   <= '0;
      dec_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      rx2_q       <= '0;
      ry2_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      rg2_q       <= rg2_d;
      out_valid_q <= out_valid_d;
      off_x_q     <= off_x_d;
      off_y_q     <= off_y_d;
      slope_x_q   <= slope_x_d;
      slope_y_q   <= slope_y_d;
      dec_q       <= dec_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      rx_q        <= rx_d;
      ry_q        <= ry_d;
      rx2_q       <= rx2_d;
      ry2_q       <= ry2_d;
    end
  end

  // product and result payload registers
  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    right_x_q <= right_x_d;
    left_x_q  <= left_x_d;
    lower_y_q <= lower_y_d;
    upper_y_q <= upper_y_d;
    last_q    <= last_d;
  end

endmodule

FILE: bench/midpoint_ellipse_rasterizer_checker.sv
// point predictor and scoreboard for the midpoint ellipse rasterizer channels
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_checker
  import mer_pkg::*;
#(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mer_in_if           in_ch_i,
  mer_out_if          out_ch_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  localparam int OUT_BITS = COORD_BITS + 2;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] right_x;
    logic signed [OUT_BITS-1:0] left_x;
    logic signed [OUT_BITS-1:0] lower_y;
    logic signed [OUT_BITS-1:0] upper_y;
    logic                       last;
  } point_t;

  point_t expected_points[$];
  int unsigned mismatch_cnt;

  // mirror of the rasterizer run state
  logic                   run_active;
  logic                   in_region_two;
  logic [31:0]            pos_x;
  logic [31:0]            pos_y;
  logic [63:0]            slope_x;
  logic [63:0]            slope_y;
  logic [63:0]            decision;
  logic [63:0]            rx_sq;
  logic [63:0]            ry_sq;
  logic [COORD_BITS-1:0]  org_x;
  logic [COORD_BITS-1:0]  org_y;

  assign err_cnt_o = mismatch_cnt;
  assign pending_o = expected_points.size();

  task automatic trace_ellipse_step(input logic op,
                                    input logic [COORD_BITS-1:0] cx,
                                    input logic [COORD_BITS-1:0] cy,
                                    input logic [RADIUS_BITS-1:0] rx,
                                    input logic [RADIUS_BITS-1:0] ry);
    point_t      pt;
    logic [63:0] a_term;
    logic [63:0] b_term;
    logic        at_end;
    if (op == OP_START) begin
      org_x         = cx;
      org_y         = cy;
      rx_sq         = 64'(rx) * 64'(rx);
      ry_sq         = 64'(ry) * 64'(ry);
      pos_x         = '0;
      pos_y         = 32'(ry);
      slope_x       = '0;
      slope_y       = 64'd2 * rx_sq * 64'(ry);
      decision      = 64'd4 * ry_sq - 64'd4 * rx_sq * 64'(ry) + rx_sq;
      in_region_two = 1'b0;
      run_active    = 1'b1;
      return;
    end
    if (!run_active) return;

    // region switch: decision restarts from the midpoint below the current point
    if (!in_region_two && !(slope_x < slope_y)) begin
      a_term        = 64'd2 * 64'(pos_x) + 64'd1;
      b_term        = 64'(pos_y) - 64'd1;
      in_region_two = 1'b1;
      decision      = ry_sq * a_term * a_term + 64'd4 * rx_sq * (b_term * b_term)
                    - 64'd4 * rx_sq * ry_sq;
    end

    at_end     = in_region_two && (pos_y == 0);
    pt.right_x = OUT_BITS'(64'(org_x) + 64'(pos_x));
    pt.left_x  = OUT_BITS'(64'(org_x) - 64'(pos_x));
    pt.lower_y = OUT_BITS'(64'(org_y) + 64'(pos_y));
    pt.upper_y = OUT_BITS'(64'(org_y) - 64'(pos_y));
    pt.last    = at_end;
    expected_points.push_back(pt);

    if (!in_region_two) begin
      pos_x   = pos_x + 1;
      slope_x = slope_x + 64'd2 * ry_sq;
      if (decision[63]) begin
        decision = decision + 64'd4 * slope_x + 64'd4 * ry_sq;
      end else begin
        pos_y    = pos_y - 1;
        slope_y  = slope_y - 64'd2 * rx_sq;
        decision = decision + 64'd4 * slope_x - 64'd4 * slope_y + 64'd4 * ry_sq;
      end
    end else if (at_end) begin
      run_active = 1'b0;
    end else begin
      pos_y   = pos_y - 1;
      slope_y = slope_y - 64'd2 * rx_sq;
      if (!decision[63] && decision != 0) begin
        decision = decision + 64'd4 * rx_sq - 64'd4 * slope_y;
      end else begin
        pos_x    = pos_x + 1;
        slope_x  = slope_x + 64'd2 * ry_sq;
        decision = decision + 64'd4 * slope_x - 64'd4 * slope_y + 64'd4 * rx_sq;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      expected_points.delete();
      mismatch_cnt  = 0;
      run_active    = 1'b0;
      in_region_two = 1'b0;
      pos_x         = '0;
      pos_y         = '0;
      slope_x       = '0;
      slope_y       = '0;
      decision      = '0;
      rx_sq         = '0;
      ry_sq         = '0;
      org_x         = '0;
      org_y         = '0;
    end else begin
      if (in_ch_i.valid && in_ch_i.ready) begin
        trace_ellipse_step(in_ch_i.opcode, in_ch_i.center_x, in_ch_i.center_y,
                           in_ch_i.radius_x, in_ch_i.radius_y);
      end
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (expected_points.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: point transfer with nothing expected: x %0d/%0d y %0d/%0d last %0b",
                     $realtime, out_ch_i.right_x, out_ch_i.left_x, out_ch_i.lower_y,
                     out_ch_i.upper_y, out_ch_i.last);
          mismatch_cnt++;
        end else begin
          want = expected_points.pop_front();
          if (want.right_x !== out_ch_i.right_x || want.left_x !== out_ch_i.left_x ||
              want.lower_y !== out_ch_i.lower_y || want.upper_y !== out_ch_i.upper_y ||
              want.last !== out_ch_i.last) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: point mismatch", $realtime);
              $display("  expected x %0d/%0d y %0d/%0d last %0b", want.right_x,
                       want.left_x, want.lower_y, want.upper_y, want.last);
              $display("  actual   x %0d/%0d y %0d/%0d last %0b", out_ch_i.right_x,
                       out_ch_i.left_x, out_ch_i.lower_y, out_ch_i.upper_y, out_ch_i.last);
            end
            mismatch_cnt++;
          end
        end
      end
    end
  end

endmodule

FILE: bench/midpoint_ellipse_rasterizer_core_tb.sv
// stimulus and verdict for the midpoint ellipse rasterizer core
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_core_tb;
  import mer_pkg::*;

  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 9;
  localparam int RADIUS_MAX  = (1 << RADIUS_BITS) - 1;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int unsigned items_sent;
  int unsigned err_cnt;
  int unsigned pending;

  mer_in_if  #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) in_bus ();
  mer_out_if #(.COORD_BITS(COORD_BITS)) out_bus ();

  midpoint_ellipse_rasterizer_core #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  midpoint_ellipse_rasterizer_checker #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_bus),
    .out_ch_i (out_bus),
    .err_cnt_o(err_cnt),
    .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // point consumer with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic op,
                           input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy,
                           input logic [RADIUS_BITS-1:0] rx,
                           input logic [RADIUS_BITS-1:0] ry);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= op;
    in_bus.center_x <= cx;
    in_bus.center_y <= cy;
    in_bus.radius_x <= rx;
    in_bus.radius_y <= ry;
    do @(posedge clk_i); while (!in_bus.ready);
    items_sent++;
  endtask

  // start transfer, then a number of steps with junk in the unused fields
  task automatic draw_ellipse(input logic [COORD_BITS-1:0] cx,
                              input logic [COORD_BITS-1:0] cy,
                              input logic [RADIUS_BITS-1:0] rx,
                              input logic [RADIUS_BITS-1:0] ry,
                              input int n_steps);
    send_item(OP_START, cx, cy, rx, ry);
    repeat (n_steps)
      send_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
  endtask

  function automatic logic [RADIUS_BITS-1:0] pick_radius();
    if ($urandom_range(99) < 70) return RADIUS_BITS'($urandom_range(12));
    return RADIUS_BITS'($urandom_range(63));
  endfunction

  initial begin
    int                     pick;
    int                     n_steps;
    int unsigned            phase_end;
    logic [RADIUS_BITS-1:0] rx;
    logic [RADIUS_BITS-1:0] ry;
    in_bus.valid    = 1'b0;
    in_bus.opcode   = OP_START;
    in_bus.center_x = '0;
    in_bus.center_y = '0;
    in_bus.radius_x = '0;
    in_bus.radius_y = '0;
    tx_idle_pct     = 34;
    rx_idle_pct     = 64;
    items_sent      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step before any start is ignored
    send_item(OP_STEP, COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX),
              RADIUS_BITS'(RADIUS_MAX), RADIUS_BITS'(RADIUS_MAX));
    // largest sizes, cut short by the next start
    draw_ellipse(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX),
                 RADIUS_BITS'(RADIUS_MAX), RADIUS_BITS'(RADIUS_MAX), 3);
    // flat ellipse: single row point flagged last, then an ignored step
    draw_ellipse('0, '0, RADIUS_BITS'(RADIUS_MAX), '0, 2);
    // no width: straight vertical run
    draw_ellipse(COORD_BITS'(COORD_MAX), '0, '0, RADIUS_BITS'(3), 5);
    draw_ellipse('0, COORD_BITS'(COORD_MAX), '0, '0, 2);
    draw_ellipse(COORD_BITS'(512), COORD_BITS'(511), RADIUS_BITS'(3), RADIUS_BITS'(2), 8);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 64;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_end = 25 + (phase + 1) * 160;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_item(1'($urandom_range(1)), COORD_BITS'($urandom), COORD_BITS'($urandom),
                    RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
        end else if (pick < 10) begin
          // large radii, dropped part way
          draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
                       RADIUS_BITS'($urandom), RADIUS_BITS'($urandom),
                       $urandom_range(1, 40));
        end else begin
          rx      = pick_radius();
          ry      = pick_radius();
          n_steps = rx + ry + 3;
          if ($urandom_range(99) < 10) n_steps = $urandom_range(n_steps - 1);
          draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), rx, ry, n_steps);
        end
      end
    end

    in_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(64'd10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/mer_pkg.sv
rtl/mer_in_if.sv
rtl/mer_out_if.sv
rtl/midpoint_ellipse_rasterizer_core.sv
bench/midpoint_ellipse_rasterizer_checker.sv
bench/midpoint_ellipse_rasterizer_core_tb.sv
